/* hw/rtl/png_pkg.sv */
// Shared widths, register indexes and reset values of the pink-noise generator.
`timescale 1ns / 1ps

package png_pkg;

  localparam int PNG_MAX_OCTAVES  = 16;
  localparam int PNG_SAMPLE_WIDTH = 16;

  localparam int HELD_W      = 16;
  localparam int GEN_W       = 32;
  localparam int GAIN_W      = 16;
  localparam int COUNT_W     = 5;
  localparam int FIRST_W     = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_OCTAVE_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_OCTAVE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_GAIN  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SEED         = 2'd3;

  localparam logic [COUNT_W-1:0] OCTAVE_COUNT_RESET = 5'd8;
  localparam logic [FIRST_W-1:0] FIRST_OCTAVE_RESET = 4'd0;
  localparam logic [GAIN_W-1:0]  OUTPUT_GAIN_RESET  = 16'd1448;
  localparam logic [GEN_W-1:0]   SEED_RESET         = 32'd1;

endpackage

/* hw/rtl/png_channels.sv */
// Valid/ready channel interfaces for the tick input and the sample output.
`timescale 1ns / 1ps

interface png_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface png_sample_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

/* hw/rtl/pink_noise_generator_core.sv */
// Voss-McCartney pink-noise generator core with a shared xorshift and accumulate sequencer.
`timescale 1ns / 1ps

//  Channel  Direction  Payload                   Beat
//  tick     in         restart (1 bit)           one per sample requested
//  noise    out        sample (SAMPLE_WIDTH, s)  one per accepted tick
//  cfg      in         cfg_index, cfg_data       one register write
//
//  A tick visits S_OCT for each active octave whose countdown is running, and S_OCT,
//  S_HELD and S_LOAD for each that reloads through the xorshift unit, then S_MUL to
//  multiply and S_RND to round. Ready is high only between ticks.
//  Reset is synchronous, clears the countdowns and output beat, and reseeds the generator.
//  A finished sample waits in the output register while the next tick is already taken.

module pink_noise_generator_core
  import png_pkg::*;
#(
  parameter int MAX_OCTAVES  = PNG_MAX_OCTAVES,
  parameter int SAMPLE_WIDTH = PNG_SAMPLE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  png_tick_if.sink               tick,
  png_sample_if.source           noise
);

  localparam int IDX_W  = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int SUM_W  = HELD_W + $clog2(MAX_OCTAVES) + 1;
  localparam int PROD_W = SUM_W + GAIN_W + 1;
  localparam int SHIFT  = GEN_W - SAMPLE_WIDTH;
  localparam int BITS_W = 6;

  localparam logic signed [PROD_W-1:0] ROUND_HALF =
    {{(PROD_W - SHIFT){1'b0}}, 1'b1, {(SHIFT - 1){1'b0}}};
  localparam logic signed [PROD_W-1:0] SAT_HI =
    {{(PROD_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SAT_LO = ~SAT_HI;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OCT  = 3'd1;
  localparam logic [2:0] S_HELD = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_RND  = 3'd5;

  logic [2:0]             state;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       last_idx;
  logic [IDX_W-1:0]       last_idx_next;
  logic [GEN_W-1:0]       gen;
  logic [MAX_OCTAVES-1:0] cd_valid;
  logic                   out_valid;

  logic [COUNT_W-1:0] octave_count;
  logic [FIRST_W-1:0] first_octave;
  logic [GAIN_W-1:0]  output_gain;
  logic [GEN_W-1:0]   seed;

  logic [GEN_W-1:0]               countdown [MAX_OCTAVES];
  logic signed [HELD_W-1:0]       held_value [MAX_OCTAVES];
  logic signed [SUM_W-1:0]        sum;
  logic signed [PROD_W-1:0]       prod;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;

  logic [GEN_W-1:0]               cd_cur;
  logic [GEN_W-1:0]               gen_step;
  logic [BITS_W-1:0]              bits;
  logic [GEN_W-1:0]               mask;
  logic [GEN_W-1:0]               rnd_masked;
  logic signed [SUM_W-1:0]        sum_add;
  logic signed [PROD_W-1:0]       rounded;
  logic signed [PROD_W-1:0]       shifted;
  logic signed [SAMPLE_WIDTH-1:0] sat_value;
  logic [COUNT_W:0]               n_req;
  logic                           tick_take;
  logic                           last_oct;
  logic                           out_load;

  function automatic logic [GEN_W-1:0] xorshift(input logic [GEN_W-1:0] x);
    logic [GEN_W-1:0] a;
    logic [GEN_W-1:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  assign tick.ready   = (state == S_IDLE);
  assign tick_take    = tick.valid && (state == S_IDLE);
  assign noise.valid  = out_valid;
  assign noise.sample = sample_q;
  assign out_load     = (state == S_RND) && (!out_valid || noise.ready);

  always_comb begin
    n_req = {1'b0, octave_count};
    if (n_req == '0) begin
      last_idx_next = '0;
    end else if (n_req > (COUNT_W + 1)'(MAX_OCTAVES)) begin
      last_idx_next = IDX_W'(MAX_OCTAVES - 1);
    end else begin
      last_idx_next = IDX_W'(n_req - (COUNT_W + 1)'(1));
    end
  end

  always_comb begin
    cd_cur     = cd_valid[idx] ? countdown[idx] : '0;
    gen_step   = xorshift(gen);
    bits       = BITS_W'(first_octave) + BITS_W'(idx) + BITS_W'(1);
    mask       = (bits >= BITS_W'(GEN_W)) ? '1 : ((GEN_W'(1) << bits[4:0]) - GEN_W'(1));
    rnd_masked = gen_step & mask;
    sum_add    = sum + SUM_W'(held_value[idx]);
    last_oct   = (idx == last_idx);
    rounded    = prod + ROUND_HALF;
    shifted    = rounded >>> SHIFT;
    if (shifted > SAT_HI) begin
      sat_value = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (shifted < SAT_LO) begin
      sat_value = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      sat_value = shifted[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= '0;
      last_idx     <= '0;
      gen          <= SEED_RESET;
      cd_valid     <= '0;
      out_valid    <= 1'b0;
      octave_count <= OCTAVE_COUNT_RESET;
      first_octave <= FIRST_OCTAVE_RESET;
      output_gain  <= OUTPUT_GAIN_RESET;
      seed         <= SEED_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OCTAVE_COUNT: octave_count <= cfg_data[COUNT_W-1:0];
          REG_FIRST_OCTAVE: first_octave <= cfg_data[FIRST_W-1:0];
          REG_OUTPUT_GAIN:  output_gain  <= cfg_data[GAIN_W-1:0];
          REG_SEED:         seed         <= cfg_data[GEN_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (noise.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (tick.valid) begin
            idx      <= '0;
            last_idx <= last_idx_next;
            if (tick.restart) begin
              cd_valid <= '0;
              gen      <= (seed == '0) ? GEN_W'(1) : seed;
            end
            state <= S_OCT;
          end
        end
        S_OCT: begin
          if (cd_cur == '0) begin
            state <= S_HELD;
          end else if (last_oct) begin
            state <= S_MUL;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_HELD: begin
          gen   <= gen_step;
          state <= S_LOAD;
        end
        S_LOAD: begin
          gen           <= gen_step;
          cd_valid[idx] <= 1'b1;
          if (last_oct) begin
            state <= S_MUL;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_OCT;
          end
        end
        S_MUL: begin
          state <= S_RND;
        end
        S_RND: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tick_take) begin
      sum <= '0;
    end
    case (state)
      S_OCT: begin
        if (cd_cur != '0) begin
          sum            <= sum_add;
          countdown[idx] <= cd_cur - GEN_W'(1);
        end
      end
      S_HELD: begin
        held_value[idx] <= gen_step[GEN_W-1 -: HELD_W];
      end
      S_LOAD: begin
        sum            <= sum_add;
        countdown[idx] <= (rnd_masked == '0) ? '0 : (rnd_masked - GEN_W'(1));
      end
      S_MUL: begin
        prod <= sum * $signed({1'b0, output_gain});
      end
      default: ;
    endcase
    if (out_load) begin
      sample_q <= sat_value;
    end
  end

endmodule

/* hw/rtl/png_checker.sv */
// Port-level checks on the pink-noise generator core and their bind.
`timescale 1ns / 1ps

module png_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           tick_valid,
  input logic                           tick_ready,
  input logic                           noise_valid,
  input logic                           noise_ready,
  input logic signed [SAMPLE_WIDTH-1:0] noise_sample
);

  logic tick_beat;

  assign tick_beat = tick_valid && tick_ready;

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !noise_valid)
    else $error("Output beat still offered after reset.");

  a_busy_after_tick: assert property (@(posedge clk) disable iff (rst)
    tick_beat |=> !tick_ready ##1 !tick_ready ##1 !tick_ready)
    else $error("Tick taken again before a sample could be made.");

  a_sample_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(noise_valid) |-> $past(!tick_ready))
    else $error("Sample offered without a tick being worked on.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    noise_valid && !noise_ready |=> noise_valid && $stable(noise_sample))
    else $error("Stalled output beat changed.");

endmodule

bind pink_noise_generator_core png_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_png_checker (
  .clk         (clk),
  .rst         (rst),
  .tick_valid  (tick.valid),
  .tick_ready  (tick.ready),
  .noise_valid (noise.valid),
  .noise_ready (noise.ready),
  .noise_sample(noise.sample)
);

/* sim/tb_pink_noise_generator_core.sv */
// Self-checking testbench of the pink-noise generator core with its own sample predictor.
`timescale 1ns / 1ps

module tb_pink_noise_generator_core
  import png_pkg::*;
();

  localparam int SHIFT        = 32 - PNG_SAMPLE_WIDTH;
  localparam int STALL_LIMIT  = 4000;
  localparam int IDLE_GAP     = 60;
  localparam int HOLD_OFF     = 300;
  localparam int REPORT_LIMIT = 10;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  png_tick_if tick_ch ();
  png_sample_if #(.SAMPLE_WIDTH(PNG_SAMPLE_WIDTH)) noise_ch ();

  pink_noise_generator_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .tick     (tick_ch),
    .noise    (noise_ch)
  );

  logic signed [HELD_W-1:0] held_vals [PNG_MAX_OCTAVES];
  logic [31:0]              octave_timer [PNG_MAX_OCTAVES];
  logic [GEN_W-1:0]         xorshift_state;
  logic [COUNT_W-1:0]       cfg_octaves;
  logic [FIRST_W-1:0]       cfg_first;
  logic [GAIN_W-1:0]        cfg_gain;
  logic [GEN_W-1:0]         cfg_seed;

  logic signed [PNG_SAMPLE_WIDTH-1:0] pending_samples [$];

  int error_count;
  int mismatch_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [GEN_W-1:0] xorshift_advance();
    logic [GEN_W-1:0] x;
    x = xorshift_state;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    xorshift_state = x;
    return x;
  endfunction

  function automatic logic signed [PNG_SAMPLE_WIDTH-1:0] next_noise_sample(input bit restart_bit);
    int unsigned n;
    int unsigned bits;
    logic [31:0] r;
    logic [31:0] mask;
    longint      acc;
    longint      prod;
    longint      q;
    longint      hi;
    longint      lo;
    hi = (longint'(1) <<< (PNG_SAMPLE_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (restart_bit) begin
      for (int i = 0; i < PNG_MAX_OCTAVES; i++) octave_timer[i] = '0;
      xorshift_state = (cfg_seed == '0) ? GEN_W'(1) : cfg_seed;
    end
    n = cfg_octaves;
    if (n == 0) n = 1;
    if (n > PNG_MAX_OCTAVES) n = PNG_MAX_OCTAVES;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      if (octave_timer[i] == '0) begin
        r = xorshift_advance();
        held_vals[i] = r[31:16];
        r = xorshift_advance();
        bits = cfg_first + i + 1;
        mask = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
        r = r & mask;
        octave_timer[i] = (r == '0) ? 32'd1 : r;
      end
      acc = acc + longint'(held_vals[i]);
      octave_timer[i] = octave_timer[i] - 32'd1;
    end
    prod = acc * longint'(cfg_gain);
    q = (prod + (longint'(1) <<< (SHIFT - 1))) >>> SHIFT;
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    return q[PNG_SAMPLE_WIDTH-1:0];
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    tick_ch.valid = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_OCTAVE_COUNT: cfg_octaves = data[COUNT_W-1:0];
      REG_FIRST_OCTAVE: cfg_first   = data[FIRST_W-1:0];
      REG_OUTPUT_GAIN:  cfg_gain    = data[GAIN_W-1:0];
      REG_SEED:         cfg_seed    = data[GEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int unsigned octaves, input int unsigned first,
                               input int unsigned gain, input logic [31:0] seed_val);
    write_reg(REG_OCTAVE_COUNT, octaves);
    write_reg(REG_FIRST_OCTAVE, first);
    write_reg(REG_OUTPUT_GAIN, gain);
    write_reg(REG_SEED, seed_val);
  endtask

  task automatic send_tick(input bit restart_bit);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_ch.valid   = 1'b0;
      tick_ch.restart = 1'($urandom_range(1));
      @(negedge clk);
    end
    tick_ch.valid   = 1'b1;
    tick_ch.restart = restart_bit;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    pending_samples.push_back(next_noise_sample(restart_bit));
  endtask

  task automatic test_reset_defaults();
    repeat (4) send_tick(1'b0);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
  endtask

  task automatic test_register_extremes();
    apply_setting(16, 15, 65535, 32'hFFFF_FFFF);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    apply_setting(0, 0, 0, 32'h0000_0001);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
    // An over-range octave count, full gain and a zero seed together.
    apply_setting(31, 0, 65535, 32'h0000_0000);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    // A new seed takes effect only at the next restart.
    write_reg(REG_SEED, 32'h8000_0000);
    repeat (2) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic test_random_traffic();
    int send_pct [4] = '{0, 73, 0, 23};
    int recv_pct [4] = '{0, 0, 73, 23};
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      for (int s = 0; s < 4; s++) begin
        apply_setting(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 16),
                      $urandom_range(15),
                      ($urandom_range(7) == 0) ? 65535 : $urandom_range(65535),
                      ($urandom_range(15) == 0) ? 32'd0 : $urandom);
        for (int k = 0; k < 50; k++) send_tick($urandom_range(15) == 0);
      end
    end
  endtask

  task automatic test_backpressure();
    apply_setting(16, 2, 4000, $urandom);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_cycles = HOLD_OFF;
    send_tick(1'b1);
    repeat (11) send_tick(1'b0);
    wait_idle();
    recv_stall_pct = 23;
    repeat (20) send_tick($urandom_range(7) == 0);
  endtask

  initial begin
    noise_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        noise_ch.ready = 1'b0;
        hold_cycles--;
      end else begin
        noise_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    logic signed [PNG_SAMPLE_WIDTH-1:0] want;
    if (!rst && noise_ch.valid && noise_ch.ready) begin
      if (pending_samples.size() == 0) begin
        error_count++;
        if (mismatch_count < REPORT_LIMIT)
          $display("unexpected sample beat: %0d", noise_ch.sample);
        mismatch_count++;
      end else begin
        want = pending_samples.pop_front();
        if (noise_ch.sample !== want) begin
          error_count++;
          if (mismatch_count < REPORT_LIMIT)
            $display("sample mismatch: expected %0d, got %0d", want, noise_ch.sample);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (noise_ch.valid && noise_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    tick_ch.valid   = 1'b0;
    tick_ch.restart = 1'b0;
    error_count     = 0;
    mismatch_count  = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_cycles     = 0;
    quiet_cycles    = 0;
    for (int i = 0; i < PNG_MAX_OCTAVES; i++) begin
      held_vals[i]    = '0;
      octave_timer[i] = '0;
    end
    cfg_octaves    = OCTAVE_COUNT_RESET;
    cfg_first      = FIRST_OCTAVE_RESET;
    cfg_gain       = OUTPUT_GAIN_RESET;
    cfg_seed       = SEED_RESET;
    xorshift_state = SEED_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    if (error_count == 0 && pending_samples.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/png_pkg.sv
hw/rtl/png_channels.sv
hw/rtl/pink_noise_generator_core.sv
hw/rtl/png_checker.sv
sim/tb_pink_noise_generator_core.sv
